// ===== rtl/edf_pkg.sv =====
// Shared constants, types and a helper function of the detector frame block.
package edf_pkg;

    localparam int TrigIterDefault = 16;
    localparam int AtanEntries     = 24;
    localparam int QueueDepth      = 2;
    localparam int QueuePtrW       = $clog2(QueueDepth);
    localparam int QueueCntW       = $clog2(QueueDepth + 1);

    // Rotator widths: x and y in Q2.30 with headroom, z as a 32-bit binary angle plus sign.
    localparam int XW = 34;
    localparam int ZW = 33;
    // Math widths: Q2.30 operands, full products, center accumulator.
    localparam int MW = 36;
    localparam int PW = 2 * MW;
    localparam int CW = 56;

    localparam logic [XW-1:0] CordicGain = XW'(652032874);

    localparam logic [29:0] AtanTab [AtanEntries] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
        30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef enum logic [1:0] {
        SelX      = 2'd0,
        SelY      = 2'd1,
        SelZ      = 2'd2,
        SelCenter = 2'd3
    } t_vsel;

    // One pose after classification. Lanes are 0 beta, 1 alpha, 2 phi.
    typedef struct packed {
        logic [5:0]        tag;
        logic [2:0]        flip;
        logic [2:0][15:0]  ang;
        logic [2:0][31:0]  ctr;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Sine and cosine of the three angles in Q2.30, with the pose's other fields.
    typedef struct packed {
        logic [5:0]          tag;
        logic [2:0][31:0]    ctr;
        logic [2:0][XW-1:0]  s;
        logic [2:0][XW-1:0]  c;
    } t_trig;

    function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
        logic [31:0] res;
        if ((&v[CW-1:31]) || !(|v[CW-1:31])) begin
            res = v[31:0];
        end else if (v[CW-1]) begin
            res = 32'h8000_0000;
        end else begin
            res = 32'h7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

// ===== rtl/euler_detector_frame.sv =====
// Top level of the detector frame block: pose in, three axes and a global center out.
//
// A pose is offered on the command channel: it is accepted at a rising clock edge
// at which start is high and busy is low. Each pose gives four result items, in
// order the X axis, the Y axis, the Z axis and the global center; each is on the
// o_ ports for exactly one cycle, marked by o_valid, and o_last flags the center.
// The receiver cannot stall, so results are simply driven when ready.
//
// The front end forms phi and folds the angles, then writes the pose into a
// two-entry queue. A pipelined rotator of TRIG_ITERATIONS stages (at most 24)
// computes all three sines and cosines, and the back end runs a ten-step sequence
// over three shared multipliers. It shows the three axes from its StCtrX, StCtrY
// and StCtrZ steps and, after a StCtrSum step, the center from its StCtrOut step.
// The back end takes a new pose only in its last step, so its sequence sets the
// pace; the queue and rotator let new poses enter while one is being finished.
// busy rises only when the queue is full.
// A synchronous active-low reset empties the queue and the pipeline and drops any
// pose in flight; no result item is shown until a new pose is accepted.
module euler_detector_frame
    import edf_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TrigIterDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [5:0]  i_det_index,
    input  logic [15:0] i_beta,
    input  logic [15:0] i_alpha,
    input  logic [15:0] i_phi_base,
    input  logic [15:0] i_phi_offset,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_center_z,
    output logic        o_valid,
    output logic [5:0]  o_det_tag,
    output logic [1:0]  o_vector_sel,
    output logic [31:0] o_comp_first,
    output logic [31:0] o_comp_second,
    output logic [31:0] o_comp_third,
    output logic        o_last
);

    t_item  front_item;
    t_item  head_item;
    t_qstat qstat;
    t_trig  trig;
    logic   push;
    logic   pop;
    logic   trig_valid;
    logic   trig_take;

    // The queue being full is the only thing that holds the command channel off.
    assign busy = qstat.full;

    edf_front u_front (
        .i_start      (start),
        .i_busy       (busy),
        .i_det_index  (i_det_index),
        .i_beta       (i_beta),
        .i_alpha      (i_alpha),
        .i_phi_base   (i_phi_base),
        .i_phi_offset (i_phi_offset),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_center_z   (i_center_z),
        .o_push       (push),
        .o_item       (front_item)
    );

    edf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (qstat)
    );

    edf_cordic #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_item),
        .i_qstat (qstat),
        .o_pop   (pop),
        .i_take  (trig_take),
        .o_valid (trig_valid),
        .o_trig  (trig)
    );

    edf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (trig_valid),
        .i_trig        (trig),
        .o_take        (trig_take),
        .o_valid       (o_valid),
        .o_det_tag     (o_det_tag),
        .o_vector_sel  (o_vector_sel),
        .o_comp_first  (o_comp_first),
        .o_comp_second (o_comp_second),
        .o_comp_third  (o_comp_third),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/edf_front.sv =====
// Front end: forms phi and folds each angle into the rotator's convergence range.
module edf_front
    import edf_pkg::*;
(
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [5:0]  i_det_index,
    input  logic [15:0] i_beta,
    input  logic [15:0] i_alpha,
    input  logic [15:0] i_phi_base,
    input  logic [15:0] i_phi_offset,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_center_z,
    output logic        o_push,
    output t_item       o_item
);

    logic [2:0][15:0] raw;
    logic [2:0][15:0] quad;

    assign raw[0] = i_beta;
    assign raw[1] = i_alpha;
    assign raw[2] = i_phi_base + i_phi_offset;

    // Angles in the left half plane are turned by a half turn; the result is negated later.
    always_comb begin
        o_item.tag    = i_det_index;
        o_item.ctr[0] = i_center_x;
        o_item.ctr[1] = i_center_y;
        o_item.ctr[2] = i_center_z;
        for (int l = 0; l < 3; l++) begin
            quad[l]         = raw[l] + 16'h4000;
            o_item.flip[l]  = quad[l][15];
            o_item.ang[l]   = quad[l][15] ? (raw[l] ^ 16'h8000) : raw[l];
        end
    end

    assign o_push        = i_start && !i_busy;

endmodule

// ===== rtl/edf_queue.sv =====
// Short queue of classified items between the front end and the rotator.
module edf_queue
    import edf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_head,
    output t_qstat o_stat
);

    t_item                r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wp;
    logic [QueuePtrW-1:0] r_rp;
    logic [QueueCntW-1:0] r_cnt;
    logic                 do_pop;

    assign o_stat.full  = (r_cnt == QueueCntW'(QueueDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== rtl/edf_cordic.sv =====
// Pipelined rotator: one iteration per stage, three angle lanes side by side.
module edf_cordic
    import edf_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TrigIterDefault
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_item  i_head,
    input  t_qstat i_qstat,
    output logic   o_pop,
    input  logic   i_take,
    output logic   o_valid,
    output t_trig  o_trig
);

    localparam int N = (TRIG_ITERATIONS > AtanEntries) ? AtanEntries : TRIG_ITERATIONS;

    logic signed [XW-1:0] r_x [N][3];
    logic signed [XW-1:0] r_y [N][3];
    logic signed [ZW-1:0] r_z [N][3];
    logic                 r_v [N];
    logic [5:0]           r_tag  [N];
    logic [2:0]           r_flip [N];
    logic [2:0][31:0]     r_ctr  [N];
    logic                 en;

    // The whole pipeline holds while its last stage waits for the back end.
    assign en    = !r_v[N-1] || i_take;
    assign o_pop = en && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= !i_qstat.empty;
            for (int s = 1; s < N; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        if (s == 0) begin : g_load
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_tag[s]  <= i_head.tag;
                    r_flip[s] <= i_head.flip;
                    r_ctr[s]  <= i_head.ctr;
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_tag[s]  <= r_tag[s-1];
                    r_flip[s] <= r_flip[s-1];
                    r_ctr[s]  <= r_ctr[s-1];
                end
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_ln
            logic signed [XW-1:0] xi;
            logic signed [XW-1:0] yi;
            logic signed [ZW-1:0] zi;
            logic signed [ZW-1:0] tz;

            assign tz = ZW'(AtanTab[s]);

            if (s == 0) begin : g_first
                assign xi = CordicGain;
                assign yi = '0;
                assign zi = ZW'($signed({i_head.ang[l], 16'h0000}));
            end else begin : g_next
                assign xi = r_x[s-1][l];
                assign yi = r_y[s-1][l];
                assign zi = r_z[s-1][l];
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!zi[ZW-1]) begin
                        r_x[s][l] <= xi - (yi >>> s);
                        r_y[s][l] <= yi + (xi >>> s);
                        r_z[s][l] <= zi - tz;
                    end else begin
                        r_x[s][l] <= xi + (yi >>> s);
                        r_y[s][l] <= yi - (xi >>> s);
                        r_z[s][l] <= zi + tz;
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_trig.s[l] = r_flip[N-1][l] ? -r_y[N-1][l] : r_y[N-1][l];
        assign o_trig.c[l] = r_flip[N-1][l] ? -r_x[N-1][l] : r_x[N-1][l];
    end

    assign o_valid    = r_v[N-1];
    assign o_trig.tag = r_tag[N-1];
    assign o_trig.ctr = r_ctr[N-1];

endmodule

// ===== rtl/edf_back.sv =====
// Back end: sequences the axis and center products over three shared multipliers.
module edf_back
    import edf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_trig       i_trig,
    output logic        o_take,
    output logic        o_valid,
    output logic [5:0]  o_det_tag,
    output logic [1:0]  o_vector_sel,
    output logic [31:0] o_comp_first,
    output logic [31:0] o_comp_second,
    output logic [31:0] o_comp_third,
    output logic        o_last
);

    typedef enum logic [3:0] {
        StProd0, StProd1, StProd2, StProd3, StProd4,
        StCtrX, StCtrY, StCtrZ, StCtrSum, StCtrOut
    } t_step;

    localparam logic signed [PW-1:0] Half30 = PW'(1) << 29;
    localparam logic signed [PW-1:0] Half16 = PW'(1) << 15;
    localparam logic signed [CW-1:0] Half14 = CW'(1) << 13;

    t_step                r_step;
    t_step                n_step;
    logic                 r_run;
    logic [5:0]           r_tag;
    logic [2:0][31:0]     r_ctr;
    logic signed [XW-1:0] r_sB, r_cB, r_sA, r_cA, r_sP, r_cP;
    logic signed [MW-1:0] r_sAcB, r_sAsB, r_cAcB, r_cAsB;
    logic signed [MW-1:0] r_t10a, r_t10b, r_t11a, r_t11b, r_ax12;
    logic signed [MW-1:0] r_t20a, r_t20b, r_t21a, r_t21b, r_ax22;
    logic signed [CW-1:0] r_p   [3];
    logic signed [CW-1:0] r_acc [3];

    logic signed [MW-1:0] ax [3][3];
    logic signed [MW-1:0] ma [3];
    logic signed [MW-1:0] mb [3];
    logic signed [PW-1:0] prod [3];
    logic signed [PW-1:0] t30 [3];
    logic signed [PW-1:0] t16 [3];
    logic signed [MW-1:0] r30 [3];
    logic signed [CW-1:0] r16 [3];
    logic signed [MW-1:0] cext [3];
    logic [2:0][31:0]     axis_out [3];
    logic [2:0][31:0]     ctr_out;

    function automatic logic signed [CW-1:0] round14(input logic signed [CW-1:0] v);
        return (v + Half14) >>> 14;
    endfunction

    assign o_take = i_valid && (!r_run || r_step == StCtrOut);
    assign n_step = t_step'(r_step + 4'd1);

    // Axis components in Q2.30.
    assign ax[0][0] = r_cAcB;
    assign ax[0][1] = r_cAsB;
    assign ax[0][2] = -MW'(r_sA);
    assign ax[1][0] = r_t10a - r_t10b;
    assign ax[1][1] = r_t11a + r_t11b;
    assign ax[1][2] = r_ax12;
    assign ax[2][0] = r_t20a + r_t20b;
    assign ax[2][1] = r_t21a - r_t21b;
    assign ax[2][2] = r_ax22;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            cext[v] = MW'($signed(r_ctr[v]));
        end
    end

    // Operand selection for each step of the sequence.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ma[j] = '0;
            mb[j] = '0;
        end
        unique case (r_step)
            StProd0: begin
                ma[0] = MW'(r_sA); mb[0] = MW'(r_cB);
                ma[1] = MW'(r_sA); mb[1] = MW'(r_sB);
                ma[2] = MW'(r_cA); mb[2] = MW'(r_cB);
            end
            StProd1: begin
                ma[0] = MW'(r_cA); mb[0] = MW'(r_sB);
                ma[1] = MW'(r_sB); mb[1] = MW'(r_cP);
                ma[2] = MW'(r_cP); mb[2] = MW'(r_cB);
            end
            StProd2: begin
                ma[0] = MW'(r_sP); mb[0] = r_sAcB;
                ma[1] = MW'(r_sP); mb[1] = r_sAsB;
                ma[2] = MW'(r_sP); mb[2] = MW'(r_cA);
            end
            StProd3: begin
                ma[0] = MW'(r_sB); mb[0] = MW'(r_sP);
                ma[1] = MW'(r_cP); mb[1] = r_sAcB;
                ma[2] = MW'(r_cP); mb[2] = r_sAsB;
            end
            StProd4: begin
                ma[0] = MW'(r_cB); mb[0] = MW'(r_sP);
                ma[1] = MW'(r_cA); mb[1] = MW'(r_cP);
            end
            StCtrX: begin
                for (int k = 0; k < 3; k++) begin
                    ma[k] = ax[0][k]; mb[k] = cext[0];
                end
            end
            StCtrY: begin
                for (int k = 0; k < 3; k++) begin
                    ma[k] = ax[1][k]; mb[k] = cext[1];
                end
            end
            StCtrZ: begin
                for (int k = 0; k < 3; k++) begin
                    ma[k] = ax[2][k]; mb[k] = cext[2];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            prod[j] = ma[j] * mb[j];
            t30[j]  = prod[j] + Half30;
            t16[j]  = prod[j] + Half16;
            r30[j]  = t30[j][30 +: MW];
            r16[j]  = t16[j][16 +: CW];
        end
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                axis_out[v][k] = sat32(round14(CW'(ax[v][k])));
            end
        end
        for (int k = 0; k < 3; k++) begin
            ctr_out[k] = sat32(round14(r_acc[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_step  <= StProd0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_run && (r_step == StCtrX || r_step == StCtrY ||
                                 r_step == StCtrZ || r_step == StCtrOut);
            if (o_take) begin
                r_run  <= 1'b1;
                r_step <= StProd0;
            end else if (r_run) begin
                if (r_step == StCtrOut) begin
                    r_run <= 1'b0;
                end else begin
                    r_step <= n_step;
                end
            end
        end

        if (o_take) begin
            r_tag <= i_trig.tag;
            r_ctr <= i_trig.ctr;
            r_sB  <= $signed(i_trig.s[0]);
            r_cB  <= $signed(i_trig.c[0]);
            r_sA  <= $signed(i_trig.s[1]);
            r_cA  <= $signed(i_trig.c[1]);
            r_sP  <= $signed(i_trig.s[2]);
            r_cP  <= $signed(i_trig.c[2]);
        end

        if (r_run) begin
            unique case (r_step)
                StProd0: begin
                    r_sAcB <= r30[0]; r_sAsB <= r30[1]; r_cAcB <= r30[2];
                end
                StProd1: begin
                    r_cAsB <= r30[0]; r_t10b <= r30[1]; r_t11a <= r30[2];
                end
                StProd2: begin
                    r_t10a <= r30[0]; r_t11b <= r30[1]; r_ax12 <= r30[2];
                end
                StProd3: begin
                    r_t20a <= r30[0]; r_t20b <= r30[1]; r_t21a <= r30[2];
                end
                StProd4: begin
                    r_t21b <= r30[0]; r_ax22 <= r30[1];
                end
                StCtrX: begin
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= '0;
                        r_p[k]   <= r16[k];
                    end
                    o_det_tag     <= r_tag;
                    o_vector_sel  <= SelX;
                    o_comp_first  <= axis_out[0][0];
                    o_comp_second <= axis_out[0][1];
                    o_comp_third  <= axis_out[0][2];
                    o_last        <= 1'b0;
                end
                StCtrY, StCtrZ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= r_acc[k] + r_p[k];
                        r_p[k]   <= r16[k];
                    end
                    o_det_tag     <= r_tag;
                    o_vector_sel  <= (r_step == StCtrY) ? SelY : SelZ;
                    o_comp_first  <= (r_step == StCtrY) ? axis_out[1][0] : axis_out[2][0];
                    o_comp_second <= (r_step == StCtrY) ? axis_out[1][1] : axis_out[2][1];
                    o_comp_third  <= (r_step == StCtrY) ? axis_out[1][2] : axis_out[2][2];
                    o_last        <= 1'b0;
                end
                StCtrSum: begin
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= r_acc[k] + r_p[k];
                    end
                end
                StCtrOut: begin
                    o_det_tag     <= r_tag;
                    o_vector_sel  <= SelCenter;
                    o_comp_first  <= ctr_out[0];
                    o_comp_second <= ctr_out[1];
                    o_comp_third  <= ctr_out[2];
                    o_last        <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/edf_checker.sv =====
// Port-level checks on the ordering of result items, bound to the top level.
module edf_checker
    import edf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic [5:0] o_det_tag,
    input logic [1:0] o_vector_sel,
    input logic       o_last
);

    a_last_on_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_vector_sel == SelCenter)))
        else $error("last flag does not match the center result");

    a_x_then_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vector_sel == SelX) |=>
            (o_valid && o_vector_sel == SelY && $stable(o_det_tag)))
        else $error("Y axis does not follow the X axis");

    a_y_then_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vector_sel == SelY) |=>
            (o_valid && o_vector_sel == SelZ && $stable(o_det_tag)))
        else $error("Z axis does not follow the Y axis");

    a_z_then_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vector_sel == SelZ) |=> !o_valid ##1
            (o_valid && o_vector_sel == SelCenter && o_det_tag == $past(o_det_tag, 2)))
        else $error("center does not follow the Z axis");

endmodule

bind euler_detector_frame edf_checker u_edf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .o_det_tag    (o_det_tag),
    .o_vector_sel (o_vector_sel),
    .o_last       (o_last)
);

// ===== tb/sv/tb_euler_detector_frame.sv =====
// Self-checking testbench of the detector frame block: directed poses, then random ones.
module tb_euler_detector_frame;
    timeunit 1ns;
    timeprecision 1ps;
    import edf_pkg::*;

    localparam int ItemCount  = 500;
    localparam int WatchLimit = 4000;
    localparam int TrigIters  = 16;

    // One expected result item, field by field.
    typedef struct {
        logic [5:0]  tag;
        t_vsel       sel;
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] third;
        logic        last;
    } t_frame_res;

    // One pose, with up to one typed-in expectation for the directed table.
    typedef struct {
        logic [5:0]  idx;
        logic [15:0] beta;
        logic [15:0] alpha;
        logic [15:0] phi_b;
        logic [15:0] phi_o;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        bit          has_fixed;
        logic [31:0] fixed_x0;
    } t_pose;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [5:0]  det_index = '0;
    logic [15:0] beta = '0;
    logic [15:0] alpha = '0;
    logic [15:0] phi_base = '0;
    logic [15:0] phi_offset = '0;
    logic [31:0] center_x = '0;
    logic [31:0] center_y = '0;
    logic [31:0] center_z = '0;
    logic        o_valid;
    logic [5:0]  o_det_tag;
    logic [1:0]  o_vector_sel;
    logic [31:0] o_comp_first;
    logic [31:0] o_comp_second;
    logic [31:0] o_comp_third;
    logic        o_last;

    t_frame_res frames_due[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         idle_pct = 0;

    always #1 clk = ~clk;

    euler_detector_frame #(.TRIG_ITERATIONS(TrigIters)) uut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_det_index(det_index), .i_beta(beta), .i_alpha(alpha),
        .i_phi_base(phi_base), .i_phi_offset(phi_offset),
        .i_center_x(center_x), .i_center_y(center_y), .i_center_z(center_z),
        .o_valid(o_valid), .o_det_tag(o_det_tag), .o_vector_sel(o_vector_sel),
        .o_comp_first(o_comp_first), .o_comp_second(o_comp_second),
        .o_comp_third(o_comp_third), .o_last(o_last)
    );

    // Rounding shift: add half an LSB, then floor (>>> on a signed value floors).
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return round_shift(a * b, 30);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Rotator: the binary angle is folded into the right half plane first, and
    // the results are negated when a fold took place.
    task automatic rotate_angle(input logic [15:0] ang, output longint s, output longint c);
        logic [31:0] a;
        bit          fold;
        longint      x, y, z, nx, step;
        a = {ang, 16'h0};
        fold = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
        if (fold) begin
            a = a + 32'h8000_0000;
        end
        x = 652032874;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < TrigIters && i < AtanEntries; i++) begin
            step = longint'(AtanTab[i]);
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - step;
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + step;
            end
            x = nx;
        end
        s = fold ? -y : y;
        c = fold ? -x : x;
    endtask

    // Works out the four result items of one pose and queues them in order.
    task automatic predict_frame(input t_pose p);
        longint     sb, cb, sa, ca, sp, cp, sacb, sasb, acc;
        longint     axis[3][3];
        longint     ctr[3];
        logic [15:0] phi;
        t_frame_res r;
        phi = p.phi_b + p.phi_o;
        rotate_angle(p.beta, sb, cb);
        rotate_angle(p.alpha, sa, ca);
        rotate_angle(phi, sp, cp);
        sacb = q30_mul(sa, cb);
        sasb = q30_mul(sa, sb);
        axis[0][0] = q30_mul(ca, cb);
        axis[0][1] = q30_mul(ca, sb);
        axis[0][2] = -sa;
        axis[1][0] = q30_mul(sp, sacb) - q30_mul(sb, cp);
        axis[1][1] = q30_mul(cp, cb) + q30_mul(sp, sasb);
        axis[1][2] = q30_mul(sp, ca);
        axis[2][0] = q30_mul(sb, sp) + q30_mul(cp, sacb);
        axis[2][1] = q30_mul(cp, sasb) - q30_mul(cb, sp);
        axis[2][2] = q30_mul(ca, cp);
        ctr[0] = longint'($signed(p.cx));
        ctr[1] = longint'($signed(p.cy));
        ctr[2] = longint'($signed(p.cz));
        r.tag = p.idx;
        r.last = 1'b0;
        for (int v = 0; v < 3; v++) begin
            r.sel = t_vsel'(v);
            r.first = clamp32(round_shift(axis[v][0], 14));
            r.second = clamp32(round_shift(axis[v][1], 14));
            r.third = clamp32(round_shift(axis[v][2], 14));
            frames_due.push_back(r);
        end
        r.sel = SelCenter;
        r.last = 1'b1;
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int v = 0; v < 3; v++) begin
                acc += round_shift(axis[v][k] * ctr[v], 16);
            end
            case (k)
                0: r.first = clamp32(round_shift(acc, 14));
                1: r.second = clamp32(round_shift(acc, 14));
                default: r.third = clamp32(round_shift(acc, 14));
            endcase
        end
        frames_due.push_back(r);
    endtask

    // Result monitor: every strobed item is compared with the oldest expectation.
    always @(posedge clk) begin
        t_frame_res e;
        if (rst_n && o_valid) begin
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result item tag %0d sel %0d", o_det_tag, o_vector_sel);
                end
            end else begin
                e = frames_due.pop_front();
                if (o_det_tag !== e.tag || o_vector_sel !== e.sel
                        || o_comp_first !== e.first || o_comp_second !== e.second
                        || o_comp_third !== e.third || o_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp tag %0d sel %0d %h %h %h last %b",
                                 e.tag, e.sel, e.first, e.second, e.third, e.last);
                        $display("          got tag %0d sel %0d %h %h %h last %b",
                                 o_det_tag, o_vector_sel, o_comp_first, o_comp_second,
                                 o_comp_third, o_last);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a pose nor a result item moves.
    always @(posedge clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchLimit) begin
            $display("euler_detector_frame regression: fail");
            $finish;
        end
    end

    // Offers one pose and holds it until accepted; start stays high afterwards so
    // that the next pose can follow at once, and is lowered by whoever pauses.
    task automatic send_pose(input t_pose p);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        det_index <= p.idx;
        beta <= p.beta;
        alpha <= p.alpha;
        phi_base <= p.phi_b;
        phi_offset <= p.phi_o;
        center_x <= p.cx;
        center_y <= p.cy;
        center_z <= p.cz;
        @(posedge clk);
        while (busy) begin
            @(posedge clk);
        end
        predict_frame(p);
        if (p.has_fixed && frames_due[frames_due.size() - 4].first !== p.fixed_x0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("directed pose %0d: predicted X.x %h, table says %h",
                         p.idx, frames_due[frames_due.size() - 4].first, p.fixed_x0);
            end
        end
        @(negedge clk);
    endtask

    // Lowers start and waits until every expected result item has come.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (frames_due.size() != 0) begin
            @(negedge clk);
        end
    endtask

    function automatic t_pose random_pose();
        t_pose p;
        p.idx = 6'($urandom);
        p.beta = 16'($urandom);
        p.alpha = 16'($urandom);
        p.phi_b = 16'($urandom);
        p.phi_o = 16'($urandom);
        // Mostly modest centers, sometimes full-range ones that may saturate.
        if ($urandom_range(3, 0) == 0) begin
            p.cx = $urandom;
            p.cy = $urandom;
            p.cz = $urandom;
        end else begin
            p.cx = 32'($signed(20'($urandom)));
            p.cy = 32'($signed(20'($urandom)));
            p.cz = 32'($signed(20'($urandom)));
        end
        p.has_fixed = 0;
        p.fixed_x0 = '0;
        return p;
    endfunction

    t_pose directed[$];

    initial begin
        t_pose p;
        int    phase;
        // Zero pose: cos of zero is the rotator gain times its scale, very close to one.
        directed.push_back('{6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             32'h0001_0000, 32'h0, 32'h0, 1'b0, '0});
        // Angle extremes and the folding boundaries at a quarter and half turn.
        directed.push_back('{6'd1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0});
        directed.push_back('{6'd2, 16'h4000, 16'hC000, 16'h8000, 16'h8000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0});
        directed.push_back('{6'd3, 16'h3FFF, 16'hBFFF, 16'h4000, 16'hC000,
                             32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0, '0});
        // Phi wraps a full turn when base plus offset overflows.
        directed.push_back('{6'd4, 16'h2000, 16'h1000, 16'hF000, 16'h2000,
                             32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 1'b0, '0});
        // Center saturation toward both ends.
        directed.push_back('{6'd5, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0});
        directed.push_back('{6'd6, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                             32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, '0});
        // Highest detector numbers are passed through unchanged.
        directed.push_back('{6'd63, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
                             32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 1'b0, '0});
        directed.push_back('{6'd62, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                             32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0});
        // Cosine at zero is the near-one gain product, so X.x reads exactly one.
        directed[0].has_fixed = 1;
        directed[0].fixed_x0 = 32'h0001_0000;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i]) begin
            send_pose(directed[i]);
        end
        // Sender holds off until every expected result item has come.
        drain();

        for (int n = 0; n < ItemCount; n++) begin
            phase = n / 100;
            case (phase)
                1: idle_pct = 68;
                2: idle_pct = 6;
                default: idle_pct = 0;
            endcase
            if (n == 250) begin
                drain();
            end
            p = random_pose();
            send_pose(p);
        end

        drain();
        repeat (40) @(negedge clk);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("euler_detector_frame regression: pass");
        end else begin
            $display("euler_detector_frame regression: fail");
        end
        $finish;
    end

endmodule
